// ----- rtl/core/tcpsq_pkg.sv -----
// ----------------------------------------------------------------------------
// tcpsq_pkg
// Shared types and constants for the two-class priority send queue.
// ----------------------------------------------------------------------------
package tcpsq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        logic [15:0] value;
        logic [7:0]  count;
        logic [15:0] address;
        logic [7:0]  opcode;
    } t_entry;

    typedef struct packed {
        t_entry head;
        logic   full;
        logic   empty;
        t_count count;
        logic   displaced_low;
        logic   accepted;
    } t_result;

endpackage

// ----- rtl/core/two_class_priority_send_queue.sv -----
// ----------------------------------------------------------------------------
// two_class_priority_send_queue
// Bounded command queue with high and low classes kept as a ring of links.
// ----------------------------------------------------------------------------
// result: each accepted item's status is registered in the output register
// throughput: one item per cycle unless the result output stalls; link table and pointers update in one pass
// head fields come from a register file read at the new head slot, with bypass
// reset (synchronous, active low): queue empty, pointers at slot 0, links ring
// the entry store is not cleared; its entries are only read once written
module two_class_priority_send_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // opcode[7:0], start_address[23:8], word_count[31:24], write_value[47:32]
    input  logic [tcpsq_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // command[0], high_priority[1]
    input  logic [tcpsq_pkg::IN_USER_W-1:0]     i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // accepted[0], displaced_low[1], entry_count[6:2], queue_empty[7],
    // queue_full[8], head_opcode[16:9], head_address[32:17],
    // head_count[40:33], head_value[56:41], zero[63:57]
    output logic [tcpsq_pkg::OUT_DATA_W-1:0]    o_m_tdata
);

    localparam int DEPTH = tcpsq_pkg::QUEUE_DEPTH;
    localparam int RES_W = $bits(tcpsq_pkg::t_result);

    tcpsq_pkg::t_slot  r_link [DEPTH];
    tcpsq_pkg::t_entry r_store [DEPTH];
    tcpsq_pkg::t_slot  r_head, r_tail, r_bnd;
    tcpsq_pkg::t_count r_count;
    logic              r_out_valid;
    tcpsq_pkg::t_result r_result;

    tcpsq_pkg::t_slot  n_head, n_tail, n_bnd;
    tcpsq_pkg::t_count n_count;
    tcpsq_pkg::t_result n_result;

    logic              s_accept;
    logic              cmd;
    logic              high;
    tcpsq_pkg::t_entry in_entry;
    tcpsq_pkg::t_slot  nt, nnt, nb, nh;
    tcpsq_pkg::t_slot  slot;
    logic              store;
    logic              displaced;
    logic              accepted;
    logic              full;
    logic              lw0_en, lw1_en, lw2_en;
    tcpsq_pkg::t_slot  lw0_a, lw0_d, lw1_a, lw1_d, lw2_a, lw2_d;
    tcpsq_pkg::t_entry head_entry;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign cmd        = i_s_tuser[0];
    assign high       = i_s_tuser[1];
    assign in_entry   = tcpsq_pkg::t_entry'(i_s_tdata);

    assign nt   = r_link[r_tail];
    assign nnt  = r_link[nt];
    assign nb   = r_link[r_bnd];
    assign nh   = r_link[r_head];
    assign full = (r_count >= tcpsq_pkg::t_count'(DEPTH));

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_bnd     = r_bnd;
        n_count   = r_count;
        slot      = r_tail;
        store     = 1'b0;
        displaced = 1'b0;
        accepted  = 1'b0;
        lw0_en    = 1'b0;
        lw1_en    = 1'b0;
        lw2_en    = 1'b0;
        lw0_a     = r_tail;
        lw0_d     = nnt;
        lw1_a     = nt;
        lw1_d     = nb;
        lw2_a     = r_bnd;
        lw2_d     = nt;
        if (cmd == tcpsq_pkg::CMD_INSERT) begin
            if (r_count == '0) begin
                slot    = r_tail;
                store   = 1'b1;
                n_count = tcpsq_pkg::t_count'(1);
            end else if (full) begin
                if (high && (r_bnd != r_tail)) begin
                    slot      = nb;
                    n_bnd     = nb;
                    store     = 1'b1;
                    displaced = 1'b1;
                end
            end else begin
                slot    = nt;
                store   = 1'b1;
                n_count = r_count + tcpsq_pkg::t_count'(1);
                if (high && (r_bnd != r_tail)) begin
                    // splice the new slot in right after the last high entry
                    lw0_en = 1'b1;
                    lw1_en = 1'b1;
                    lw2_en = 1'b1;
                    n_bnd  = nt;
                end else begin
                    n_tail = nt;
                    if (high) begin
                        n_bnd = nt;
                    end
                end
            end
            accepted = store;
        end else if (r_count != '0) begin
            accepted = 1'b1;
            n_count  = r_count - tcpsq_pkg::t_count'(1);
            if (r_count > tcpsq_pkg::t_count'(1)) begin
                // old head slot moves to the start of the free part
                lw0_en = 1'b1;
                lw0_a  = r_head;
                lw0_d  = nt;
                lw1_en = 1'b1;
                lw1_a  = r_tail;
                lw1_d  = r_head;
                n_head = nh;
                if (r_bnd == r_head) begin
                    n_bnd = nh;
                end
            end
        end

        if (store && (slot == n_head)) begin
            head_entry = in_entry;
        end else begin
            head_entry = r_store[n_head];
        end

        n_result.accepted      = accepted;
        n_result.displaced_low = displaced;
        n_result.count         = n_count;
        n_result.empty         = (n_count == '0);
        n_result.full          = (n_count >= tcpsq_pkg::t_count'(DEPTH));
        n_result.head          = (n_count == '0) ? '0 : head_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_link[i] <= tcpsq_pkg::t_slot'((i + 1) % DEPTH);
            end
            r_head      <= '0;
            r_tail      <= '0;
            r_bnd       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                if (lw0_en) begin
                    r_link[lw0_a] <= lw0_d;
                end
                if (lw1_en) begin
                    r_link[lw1_a] <= lw1_d;
                end
                if (lw2_en) begin
                    r_link[lw2_a] <= lw2_d;
                end
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_bnd   <= n_bnd;
                r_count <= n_count;
            end
            if (s_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && store) begin
            r_store[slot] <= in_entry;
        end
        if (s_accept) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(tcpsq_pkg::OUT_DATA_W - RES_W){1'b0}}, r_result};

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tcpsq_pkg::t_count'(DEPTH))
        else $error("held count above queue depth");

    a_release_dec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && cmd == tcpsq_pkg::CMD_RELEASE && r_count != '0)
        |=> (r_count == $past(r_count) - tcpsq_pkg::t_count'(1)))
        else $error("release did not remove one entry");

    a_displace_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.displaced_low) |-> (r_result.full && r_result.accepted))
        else $error("displacement reported on a queue that is not full");

    a_single_entry : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == tcpsq_pkg::t_count'(1)) |-> (r_head == r_tail))
        else $error("single entry but head and tail differ");

endmodule

// ----- tb/sv/tb_two_class_priority_send_queue.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_class_priority_send_queue
// Self-checking bench for the two-class priority send queue. Insert and
// release items stream in with random bursts and gaps while the result side
// stalls on changing ready patterns. A behavioral copy of the linked ring
// predicts each status item, which is compared field by field on arrival.
// ----------------------------------------------------------------------------
module tb_two_class_priority_send_queue;

    localparam logic CLASS_LOW      = 1'b0;
    localparam logic CLASS_HIGH     = 1'b1;
    localparam int   TOTAL_REQUESTS = 1550;
    localparam int   CYCLE_LIMIT    = 400000;
    localparam int   RESULT_W       = $bits(tcpsq_pkg::t_result);

    typedef struct {
        logic              command;
        logic              high;
        tcpsq_pkg::t_entry entry;
        bit                sync;
    } t_queue_request;

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    // opcode, start_address, word_count, write_value
    logic [tcpsq_pkg::IN_DATA_W-1:0]  i_s_tdata  = '0;
    // command, high_priority
    logic [tcpsq_pkg::IN_USER_W-1:0]  i_s_tuser  = '0;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    // accepted, displaced_low, entry_count, queue_empty, queue_full,
    // head_opcode, head_address, head_count, head_value, zero padding
    logic [tcpsq_pkg::OUT_DATA_W-1:0] o_m_tdata;

    t_queue_request      request_q[$];
    tcpsq_pkg::t_result  status_q[$];
    t_queue_request      drv_item;

    tcpsq_pkg::t_slot  ring_link [tcpsq_pkg::QUEUE_DEPTH];
    tcpsq_pkg::t_entry slot_entry[tcpsq_pkg::QUEUE_DEPTH];
    tcpsq_pkg::t_slot  head_ptr;
    tcpsq_pkg::t_slot  tail_ptr;
    tcpsq_pkg::t_slot  boundary_ptr;
    int                held_entries;

    int          cycle_count   = 0;
    int          sent_count    = 0;
    int          result_count  = 0;
    int          fail_count    = 0;
    int          burst_left    = 20;
    int          gap_left      = 0;
    bit          s_fire;
    logic [31:0] ready_pattern = '1;

    int n_displaced     = 0;
    int n_refused       = 0;
    int n_full          = 0;
    int n_empty_release = 0;

    two_class_priority_send_queue i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic tcpsq_pkg::t_result advance_queue_model(input t_queue_request rq);
        tcpsq_pkg::t_result r;
        tcpsq_pkg::t_slot   slot;
        tcpsq_pkg::t_slot   new_head;
        bit                 store;
        r     = '0;
        slot  = '0;
        store = 1'b0;
        if (rq.command == tcpsq_pkg::CMD_INSERT) begin
            store = 1'b1;
            if (held_entries == 0) begin
                slot         = tail_ptr;
                held_entries = 1;
            end else if (held_entries >= tcpsq_pkg::QUEUE_DEPTH) begin
                if (rq.high == CLASS_HIGH && boundary_ptr != tail_ptr) begin
                    slot            = ring_link[boundary_ptr];
                    boundary_ptr    = slot;
                    r.displaced_low = 1'b1;
                    n_displaced++;
                end else begin
                    store = 1'b0;
                    n_refused++;
                end
            end else begin
                slot = ring_link[tail_ptr];
                if (rq.high == CLASS_HIGH && boundary_ptr != tail_ptr) begin
                    // splice the free slot in right after the last high entry
                    ring_link[tail_ptr]     = ring_link[slot];
                    ring_link[slot]         = ring_link[boundary_ptr];
                    ring_link[boundary_ptr] = slot;
                    boundary_ptr            = slot;
                end else begin
                    tail_ptr = slot;
                    if (rq.high == CLASS_HIGH)
                        boundary_ptr = slot;
                end
                held_entries++;
            end
            if (store) begin
                slot_entry[slot] = rq.entry;
                r.accepted       = 1'b1;
            end
        end else if (held_entries != 0) begin
            if (held_entries > 1) begin
                // old head slot goes back to the front of the free part
                new_head            = ring_link[head_ptr];
                ring_link[head_ptr] = ring_link[tail_ptr];
                ring_link[tail_ptr] = head_ptr;
                if (boundary_ptr == head_ptr)
                    boundary_ptr = new_head;
                head_ptr = new_head;
            end
            held_entries--;
            r.accepted = 1'b1;
        end else begin
            n_empty_release++;
        end
        r.count = tcpsq_pkg::t_count'(held_entries);
        r.empty = (held_entries == 0);
        r.full  = (held_entries >= tcpsq_pkg::QUEUE_DEPTH);
        if (r.full)
            n_full++;
        if (held_entries != 0)
            r.head = slot_entry[head_ptr];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void compare_status(input tcpsq_pkg::t_result want,
                                           input logic [tcpsq_pkg::OUT_DATA_W-1:0] data);
        tcpsq_pkg::t_result got;
        got = tcpsq_pkg::t_result'(data[RESULT_W-1:0]);
        check_field("accepted", 64'(want.accepted), 64'(got.accepted));
        check_field("displaced_low", 64'(want.displaced_low), 64'(got.displaced_low));
        check_field("entry_count", 64'(want.count), 64'(got.count));
        check_field("queue_empty", 64'(want.empty), 64'(got.empty));
        check_field("queue_full", 64'(want.full), 64'(got.full));
        check_field("head_opcode", 64'(want.head.opcode), 64'(got.head.opcode));
        check_field("head_address", 64'(want.head.address), 64'(got.head.address));
        check_field("head_count", 64'(want.head.count), 64'(got.head.count));
        check_field("head_value", 64'(want.head.value), 64'(got.head.value));
        check_field("padding", '0, 64'(data[tcpsq_pkg::OUT_DATA_W-1:RESULT_W]));
    endfunction

    function automatic logic [15:0] field_value(input int bits);
        logic [15:0] mask;
        mask = (16'h1 << bits) - 16'h1;
        if (bits >= 16)
            mask = 16'hffff;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return mask;
            default: return 16'($urandom) & mask;
        endcase
    endfunction

    function automatic tcpsq_pkg::t_entry make_entry();
        tcpsq_pkg::t_entry e;
        e.opcode  = 8'(field_value(8));
        e.address = field_value(16);
        e.count   = 8'(field_value(8));
        e.value   = field_value(16);
        return e;
    endfunction

    function automatic void add_request(input logic command, input logic high,
                                        input tcpsq_pkg::t_entry entry, input bit sync);
        t_queue_request rq;
        rq.command = command;
        rq.high    = high;
        rq.entry   = entry;
        rq.sync    = sync;
        request_q.push_back(rq);
    endfunction

    // sender: bursts and gaps, sync items wait until every status item is back
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            s_fire = i_s_tvalid && o_s_tready;
            if (s_fire) begin
                status_q.push_back(advance_queue_model(drv_item));
                sent_count <= sent_count + 1;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (request_q.size() != 0 &&
                             !(request_q[0].sync && (s_fire || sent_count != result_count))) begin
                    drv_item = request_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= drv_item.entry;
                    i_s_tuser  <= {drv_item.high, drv_item.command};
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
                        gap_left   = $urandom_range(1, 8);
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: ready follows a random pattern that is redrawn whenever the low bits of the cycle counter wrap
    always @(posedge i_clk) begin
        if (cycle_count[5:0] == 6'd0) begin
            case ($urandom_range(0, 3))
                0:       ready_pattern <= '1;
                1:       ready_pattern <= $urandom | $urandom;
                2:       ready_pattern <= $urandom & $urandom;
                default: ready_pattern <= $urandom;
            endcase
        end
        i_m_tready <= ready_pattern[cycle_count[4:0]];
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            result_count <= result_count + 1;
            if (status_q.size() == 0) begin
                $error("status item with no request pending: 0x%0h", o_m_tdata);
                fail_count++;
            end else begin
                compare_status(status_q.pop_front(), o_m_tdata);
            end
        end
    end

    initial begin
        int  n;
        int  k;
        int  kind;
        int  hi_pct;
        int  planned;
        bit  first;
        bit  sync_now;
        bit  timed_out;

        for (int i = 0; i < tcpsq_pkg::QUEUE_DEPTH; i++)
            ring_link[i] = tcpsq_pkg::t_slot'((i + 1) % tcpsq_pkg::QUEUE_DEPTH);
        head_ptr     = '0;
        tail_ptr     = '0;
        boundary_ptr = '0;
        held_entries = 0;

        // empty queue, last entry, then all high up to full
        add_request(tcpsq_pkg::CMD_RELEASE, CLASS_LOW, make_entry(), 1'b0);
        add_request(tcpsq_pkg::CMD_INSERT, CLASS_LOW, '0, 1'b0);
        add_request(tcpsq_pkg::CMD_RELEASE, CLASS_HIGH, make_entry(), 1'b0);
        add_request(tcpsq_pkg::CMD_INSERT, CLASS_HIGH, '1, 1'b0);
        for (k = 0; k < tcpsq_pkg::QUEUE_DEPTH - 1; k++)
            add_request(tcpsq_pkg::CMD_INSERT, CLASS_HIGH, make_entry(), 1'b0);
        // full with no low entry, then with one low entry to displace
        add_request(tcpsq_pkg::CMD_INSERT, CLASS_HIGH, make_entry(), 1'b0);
        add_request(tcpsq_pkg::CMD_INSERT, CLASS_LOW, make_entry(), 1'b0);
        add_request(tcpsq_pkg::CMD_RELEASE, CLASS_LOW, make_entry(), 1'b0);
        add_request(tcpsq_pkg::CMD_INSERT, CLASS_LOW, make_entry(), 1'b0);
        add_request(tcpsq_pkg::CMD_INSERT, CLASS_HIGH, make_entry(), 1'b0);
        add_request(tcpsq_pkg::CMD_INSERT, CLASS_HIGH, '0, 1'b0);

        planned = request_q.size();
        first   = 1'b1;
        while (planned < TOTAL_REQUESTS) begin
            kind   = $urandom_range(0, 9);
            hi_pct = 25 * $urandom_range(0, 4);
            if (kind <= 3)
                n = $urandom_range(6, 24);
            else if (kind <= 6)
                n = $urandom_range(3, 20);
            else
                n = $urandom_range(8, 40);
            for (k = 0; k < n; k++) begin
                sync_now = (k == 0) && (first || $urandom_range(0, 11) == 0);
                if (kind <= 3)
                    add_request(tcpsq_pkg::CMD_INSERT,
                                ($urandom_range(0, 99) < hi_pct) ? CLASS_HIGH : CLASS_LOW,
                                make_entry(), sync_now);
                else if (kind <= 6)
                    add_request(tcpsq_pkg::CMD_RELEASE, 1'($urandom), make_entry(),
                                sync_now);
                else
                    add_request(1'($urandom), 1'($urandom), make_entry(), sync_now);
                first = 1'b0;
            end
            planned += n;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(request_q.size() == 0 && !i_s_tvalid && status_q.size() == 0) &&
               cycle_count < CYCLE_LIMIT)
            @(negedge i_clk);
        timed_out = (cycle_count >= CYCLE_LIMIT);

        if (timed_out) begin
            $display("CHECK FAILED");
        end else begin
            repeat (16) @(negedge i_clk);
            $display("%0d requests, %0d status items in %0d cycles", sent_count,
                     result_count, cycle_count);
            $display("%0d low entries displaced, %0d inserts refused, %0d full, %0d empty releases",
                     n_displaced, n_refused, n_full, n_empty_release);
            if (fail_count == 0)
                $display("CHECK OK");
            else
                $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
